FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Implication checked on every rising edge, reset included.
`define CHK_RAW(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: hdl/ttb_pkg.sv
// Package with item types and constants of the tangent basis unit.
`timescale 1ns / 1ps
package ttb_pkg;

  localparam int QueueDepth = 2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic mesh_start;
  } vtx_item_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic degenerate;
  } res_item_t;

  typedef struct packed {
    logic [2:0][32:0] e1;
    logic [2:0][32:0] e2;
    logic [32:0] du1;
    logic [32:0] dv1;
    logic [32:0] du2;
    logic [32:0] dv2;
  } tri_t;

endpackage

FILE: hdl/ttb_front.sv
// Front end: groups vertices into triangles and queues their edge deltas.
`timescale 1ns / 1ps
module ttb_front import ttb_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      vtx_valid,
  output logic      vtx_stall,
  input  vtx_item_t vtx,
  output logic      tri_valid,
  input  logic      tri_pop,
  output tri_t      tri_data
);

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  logic [31:0] pos0 [3];
  logic [31:0] pos1 [3];
  logic [31:0] uv0 [2];
  logic [31:0] uv1 [2];
  logic [1:0] phase;
  logic [1:0] ph_eff;
  logic [31:0] cur [3];
  tri_t q_mem [Depth];
  logic [Aw-1:0] wp, rp;
  logic [Aw:0] count;
  logic accept, push, pop;
  tri_t entry;

  assign cur[0] = vtx.pos_x;
  assign cur[1] = vtx.pos_y;
  assign cur[2] = vtx.pos_z;

  assign vtx_stall = (count == (Aw+1)'(Depth));
  assign accept = vtx_valid && !vtx_stall;
  assign ph_eff = (vtx.mesh_start || phase == 2'd3) ? 2'd0 : phase;
  assign push = accept && (ph_eff == 2'd2);
  assign pop = tri_pop && tri_valid;
  assign tri_valid = (count != '0);
  assign tri_data = q_mem[rp];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      entry.e1[c] = {pos1[c][31], pos1[c]} - {pos0[c][31], pos0[c]};
      entry.e2[c] = {cur[c][31], cur[c]} - {pos0[c][31], pos0[c]};
    end
    entry.du1 = {uv1[0][31], uv1[0]} - {uv0[0][31], uv0[0]};
    entry.dv1 = {uv1[1][31], uv1[1]} - {uv0[1][31], uv0[1]};
    entry.du2 = {vtx.tex_u[31], vtx.tex_u} - {uv0[0][31], uv0[0]};
    entry.dv2 = {vtx.tex_v[31], vtx.tex_v} - {uv0[1][31], uv0[1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        if (ph_eff == 2'd0) begin
          for (int c = 0; c < 3; c++) pos0[c] <= cur[c];
          uv0[0] <= vtx.tex_u;
          uv0[1] <= vtx.tex_v;
          phase <= 2'd1;
        end else if (ph_eff == 2'd1) begin
          for (int c = 0; c < 3; c++) pos1[c] <= cur[c];
          uv1[0] <= vtx.tex_u;
          uv1[1] <= vtx.tex_v;
          phase <= 2'd2;
        end else begin
          phase <= 2'd0;
        end
      end
      if (push) begin
        q_mem[wp] <= entry;
        wp <= (wp == Aw'(Depth - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) rp <= (rp == Aw'(Depth - 1)) ? '0 : rp + 1'b1;
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

endmodule

FILE: hdl/ttb_back.sv
// Back end: products, normalization and the result register.
`timescale 1ns / 1ps
module ttb_back import ttb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      tri_valid,
  output logic      tri_pop,
  input  tri_t      tri_data,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  typedef enum logic [10:0] {
    IDLE  = 11'b00000000001,
    MUL   = 11'b00000000010,
    DET   = 11'b00000000100,
    LOAD  = 11'b00000001000,
    SHIFT = 11'b00000010000,
    SQ    = 11'b00000100000,
    SQRT  = 11'b00001000000,
    DINIT = 11'b00010000000,
    DIV   = 11'b00100000000,
    DWR   = 11'b01000000000,
    DONE  = 11'b10000000000
  } state_t;

  state_t state;
  tri_t trd;
  logic signed [66:0] acc [7];
  logic [3:0] k;
  logic vi;
  logic [1:0] ci;
  logic [66:0] m [3];
  logic sg [3];
  logic [61:0] sum;
  logic [63:0] sx, sr, sbit, rb;
  logic [4:0] it;
  logic [46:0] rem, dsh;
  logic [14:0] q;
  logic [3:0] j;
  logic [15:0] rv [6];
  logic degen;

  logic signed [32:0] opa, opb;
  logic signed [65:0] prod;
  logic [2:0] dst;
  logic [3:0] ki;
  logic [66:0] absv [3];
  logic [66:0] orv;
  logic [29:0] sv;
  logic [59:0] sqv;
  logic [61:0] sum_n;
  logic [15:0] qs;
  logic [2:0] rix;

  assign tri_pop = (state == IDLE) && tri_valid;

  always_comb begin
    ki = 4'd0;
    opa = $signed(trd.du1);
    opb = $signed(trd.dv2);
    dst = 3'd0;
    if (k < 4'd2) begin
      if (k[0]) begin
        opa = $signed(trd.du2);
        opb = $signed(trd.dv1);
      end
    end else if (k < 4'd8) begin
      ki = k - 4'd2;
      dst = 3'd1 + 3'(ki[2:1]);
      if (k[0]) begin
        opa = $signed(trd.dv1);
        opb = $signed(trd.e2[ki[2:1]]);
      end else begin
        opa = $signed(trd.dv2);
        opb = $signed(trd.e1[ki[2:1]]);
      end
    end else begin
      ki = k - 4'd8;
      dst = 3'd4 + 3'(ki[2:1]);
      if (k[0]) begin
        opa = $signed(trd.du2);
        opb = $signed(trd.e1[ki[2:1]]);
      end else begin
        opa = $signed(trd.du1);
        opb = $signed(trd.e2[ki[2:1]]);
      end
    end
    prod = opa * opb;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      absv[c] = acc[vi ? 4 + c : 1 + c][66] ? 67'(-acc[vi ? 4 + c : 1 + c])
                                            : 67'(acc[vi ? 4 + c : 1 + c]);
    end
    orv = m[0] | m[1] | m[2];
    sv = m[ci][66:37];
    sqv = 60'(sv) * 60'(sv);
    sum_n = sum + 62'(sqv);
    rb = sr + sbit;
    dsh = 47'({sr[31:0], 1'b0}) << j;
    qs = (sg[ci] ^ acc[0][66]) ? 16'(-{1'b0, q}) : {1'b0, q};
    rix = vi ? 3'd3 + 3'(ci) : 3'(ci);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != DONE) res_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (tri_valid) begin
            trd <= tri_data;
            for (int a = 0; a < 7; a++) acc[a] <= '0;
            k <= 4'd0;
            degen <= 1'b0;
            state <= MUL;
          end
        end
        MUL: begin
          if (k[0]) acc[dst] <= acc[dst] - {prod[65], prod};
          else acc[dst] <= acc[dst] + {prod[65], prod};
          k <= k + 4'd1;
          if (k == 4'd13) state <= DET;
        end
        DET: begin
          vi <= 1'b0;
          if (acc[0] == '0) begin
            degen <= 1'b1;
            state <= DONE;
          end else begin
            state <= LOAD;
          end
        end
        LOAD: begin
          for (int c = 0; c < 3; c++) begin
            m[c] <= absv[c];
            sg[c] <= acc[vi ? 4 + c : 1 + c][66];
          end
          ci <= 2'd0;
          sum <= '0;
          if ((absv[0] | absv[1] | absv[2]) == '0) begin
            degen <= 1'b1;
            state <= DONE;
          end else begin
            state <= SHIFT;
          end
        end
        SHIFT: begin
          if (orv[66:59] == 8'd0) begin
            for (int c = 0; c < 3; c++) m[c] <= m[c] << 8;
          end else if (!orv[66]) begin
            for (int c = 0; c < 3; c++) m[c] <= m[c] << 1;
          end else begin
            state <= SQ;
          end
        end
        SQ: begin
          sum <= sum_n;
          if (ci == 2'd2) begin
            sx <= {2'b00, sum_n};
            sr <= '0;
            sbit <= 64'h4000_0000_0000_0000;
            it <= 5'd31;
            ci <= 2'd0;
            state <= SQRT;
          end else begin
            ci <= ci + 2'd1;
          end
        end
        SQRT: begin
          if (sx >= rb) begin
            sx <= sx - rb;
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sbit <= sbit >> 2;
          it <= it - 5'd1;
          if (it == 5'd0) state <= DINIT;
        end
        DINIT: begin
          rem <= 47'({sv, 15'd0}) + 47'(sr[31:0]);
          j <= 4'd14;
          q <= '0;
          state <= DIV;
        end
        DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            q[j] <= 1'b1;
          end
          j <= j - 4'd1;
          if (j == 4'd0) state <= DWR;
        end
        DWR: begin
          rv[rix] <= qs;
          if (ci != 2'd2) begin
            ci <= ci + 2'd1;
            state <= DINIT;
          end else if (!vi) begin
            vi <= 1'b1;
            state <= LOAD;
          end else begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res.tangent_x <= degen ? '0 : rv[0];
            res.tangent_y <= degen ? '0 : rv[1];
            res.tangent_z <= degen ? '0 : rv[2];
            res.bitangent_x <= degen ? '0 : rv[3];
            res.bitangent_y <= degen ? '0 : rv[4];
            res.bitangent_z <= degen ? '0 : rv[5];
            res.degenerate <= degen;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/triangle_tangent_basis_unit.sv
// Top level of the per-triangle tangent and bitangent unit.
//
// One vertex item enters on vtx when vtx_valid is high and vtx_stall is low.
// Every third vertex of a mesh closes a triangle; mesh_start makes a vertex
// the first of a new triangle. Each triangle gives one result item on res:
// a unit tangent and bitangent in Q1.14 and a degenerate flag.
// The front end takes one vertex per cycle while its two-entry triangle
// queue has room, and raises vtx_stall only when that queue is full.
// The back end works on one triangle at a time with one 33 by 33 bit
// multiplier for fourteen products, then per vector a normalizing shift,
// three squares, a 32-step square root and three 15-step divisions.
// A zero determinant, or a zero tangent or bitangent, ends the work early
// and gives a degenerate result.
// The result waits in its register while res_stall is high, and the back
// end holds its next result in DONE until the register is free.
// Reset empties the queue, clears the vertex phase and drops res_valid.
`timescale 1ns / 1ps
module triangle_tangent_basis_unit import ttb_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      vtx_valid,
  output logic      vtx_stall,
  input  vtx_item_t vtx,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  logic tri_valid, tri_pop;
  tri_t tri_data;

  ttb_front #(.Depth(Depth)) u_front (
    .clk, .rst, .vtx_valid, .vtx_stall, .vtx,
    .tri_valid, .tri_pop, .tri_data
  );

  ttb_back u_back (
    .clk, .rst, .tri_valid, .tri_pop, .tri_data,
    .res_valid, .res_stall, .res
  );

endmodule

FILE: hdl/ttb_checker.sv
// Port-level checker for the tangent basis unit and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ttb_checker import ttb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_stall,
  input res_item_t res
);

  logic vec_zero;
  logic x_in_range;

  assign vec_zero = (res.tangent_x == 16'sd0) && (res.tangent_y == 16'sd0) &&
                    (res.tangent_z == 16'sd0) && (res.bitangent_x == 16'sd0) &&
                    (res.bitangent_y == 16'sd0) && (res.bitangent_z == 16'sd0);
  assign x_in_range = (res.tangent_x <= 16'sd16384) && (res.tangent_x >= -16'sd16384) &&
                      (res.bitangent_x <= 16'sd16384) && (res.bitangent_x >= -16'sd16384);

  `CHK_ALWAYS(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res))
  `CHK_ALWAYS(a_degen_zero, clk, rst, res_valid && res.degenerate |-> vec_zero)
  `CHK_ALWAYS(a_unit_range, clk, rst, res_valid && !res.degenerate |-> x_in_range)
  `CHK_RAW(a_reset_idle, clk, $past(rst) |-> !res_valid)

endmodule

bind triangle_tangent_basis_unit ttb_checker u_ttb_checker (
  .clk, .rst, .res_valid, .res_stall, .res
);

FILE: dv/testbench.sv
// Self-checking testbench for the triangle tangent basis unit, driven by vertex streams.
`timescale 1ns / 1ps
module testbench;
  import ttb_pkg::*;

  localparam int CycleLimit = 1000000;

  class tangent_scoreboard;
    logic signed [31:0] held_pos[6];
    logic signed [31:0] held_uv[4];
    logic [1:0] phase;
    res_item_t pending[$];
    int errors;

    function new();
      errors = 0;
      phase = 0;
      foreach (held_pos[i]) held_pos[i] = '0;
      foreach (held_uv[i]) held_uv[i] = '0;
    endfunction

    function automatic int bit_len(logic [127:0] m);
      for (int i = 127; i >= 0; i--) if (m[i]) return i + 1;
      return 0;
    endfunction

    function automatic logic [63:0] root(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Returns 0 for the zero vector.
    function automatic bit normalize(input logic signed [127:0] v[3], input bit flip,
                                     output logic signed [15:0] u[3]);
      logic [127:0] m[3];
      logic [63:0] s[3], sum, len, q;
      int top, b, sh;
      top = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = v[i][127] ? -v[i] : v[i];
        b = bit_len(m[i]);
        if (b > top) top = b;
      end
      if (top == 0) return 0;
      sh = top - 30;
      for (int i = 0; i < 3; i++) begin
        if (sh <= 0) s[i] = 64'((m[i] << (-sh)) & 128'h3FFF_FFFF);
        else s[i] = 64'(m[i] >> sh);
        sum = sum + s[i] * s[i];
      end
      len = root(sum);
      for (int i = 0; i < 3; i++) begin
        q = (2 * s[i] * 64'd16384 + len) / (2 * len);
        u[i] = (v[i][127] != flip) ? -16'(q) : 16'(q);
      end
      return 1;
    endfunction

    function void note_vertex(vtx_item_t it);
      logic signed [127:0] e1[3], e2[3], t[3], bt[3];
      logic signed [127:0] du1, dv1, du2, dv2, det;
      logic signed [31:0] cur[3];
      logic signed [15:0] tu[3], bu[3];
      res_item_t r;
      bit okt, okb;
      cur[0] = it.pos_x;
      cur[1] = it.pos_y;
      cur[2] = it.pos_z;
      if (it.mesh_start || phase > 2) phase = 0;
      if (phase < 2) begin
        for (int i = 0; i < 3; i++) held_pos[phase * 3 + i] = cur[i];
        held_uv[phase * 2] = it.tex_u;
        held_uv[phase * 2 + 1] = it.tex_v;
        phase = phase + 1;
        return;
      end
      phase = 0;
      for (int i = 0; i < 3; i++) begin
        e1[i] = held_pos[3 + i] - held_pos[i];
        e2[i] = cur[i] - held_pos[i];
      end
      du1 = held_uv[2] - held_uv[0];
      dv1 = held_uv[3] - held_uv[1];
      du2 = it.tex_u - held_uv[0];
      dv2 = it.tex_v - held_uv[1];
      det = du1 * dv2 - du2 * dv1;
      for (int i = 0; i < 3; i++) begin
        t[i] = dv2 * e1[i] - dv1 * e2[i];
        bt[i] = du1 * e2[i] - du2 * e1[i];
      end
      okt = normalize(t, det[127], tu);
      okb = normalize(bt, det[127], bu);
      r = '0;
      if (det == 0 || !okt || !okb) begin
        r.degenerate = 1'b1;
      end else begin
        r.tangent_x = tu[0];
        r.tangent_y = tu[1];
        r.tangent_z = tu[2];
        r.bitangent_x = bu[0];
        r.bitangent_y = bu[1];
        r.bitangent_z = bu[2];
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check(res_item_t got);
      res_item_t e;
      if (pending.size() == 0) begin
        $error("result item with none expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.tangent_x !== e.tangent_x) begin
        $error("tangent_x expected %0d got %0d", e.tangent_x, got.tangent_x); errors++;
      end
      if (got.tangent_y !== e.tangent_y) begin
        $error("tangent_y expected %0d got %0d", e.tangent_y, got.tangent_y); errors++;
      end
      if (got.tangent_z !== e.tangent_z) begin
        $error("tangent_z expected %0d got %0d", e.tangent_z, got.tangent_z); errors++;
      end
      if (got.bitangent_x !== e.bitangent_x) begin
        $error("bitangent_x expected %0d got %0d", e.bitangent_x, got.bitangent_x); errors++;
      end
      if (got.bitangent_y !== e.bitangent_y) begin
        $error("bitangent_y expected %0d got %0d", e.bitangent_y, got.bitangent_y); errors++;
      end
      if (got.bitangent_z !== e.bitangent_z) begin
        $error("bitangent_z expected %0d got %0d", e.bitangent_z, got.bitangent_z); errors++;
      end
      if (got.degenerate !== e.degenerate) begin
        $error("degenerate expected %0b got %0b", e.degenerate, got.degenerate); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic vtx_valid, vtx_stall, res_valid, res_stall;
  vtx_item_t vtx;
  res_item_t res;
  tangent_scoreboard sb;
  int cycles;
  bit burst_mode;

  triangle_tangent_basis_unit uut (
    .clk(clk), .rst(rst),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check(res);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    int g;
    res_stall = 0;
    forever begin
      @(negedge clk);
      if (burst_mode) begin
        res_stall = 0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          res_stall = 1;
          repeat (g) @(negedge clk);
        end
        res_stall = 0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end
    end
  end

  function automatic vtx_item_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic [31:0] u, logic [31:0] v, bit ms);
    vtx_item_t it;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.tex_u = u;
    it.tex_v = v;
    it.mesh_start = ms;
    return it;
  endfunction

  function automatic logic [31:0] rand_word(int kind);
    logic [31:0] w;
    w = $urandom;
    case (kind)
      0: return w;
      1: return {{12{w[19]}}, w[19:0]};
      2: return {{20{w[11]}}, w[11:0]};
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic vtx_item_t rand_vertex(bit ms, bit same_uv, logic [31:0] su,
                                            logic [31:0] sv);
    int k;
    vtx_item_t it;
    k = $urandom_range(0, 9);
    k = (k < 4) ? 0 : (k < 7) ? 1 : (k < 9) ? 2 : 3;
    it = mk(rand_word(k), rand_word(k), rand_word(k), rand_word(k), rand_word(k), ms);
    if (same_uv) begin
      it.tex_u = su;
      it.tex_v = sv;
    end
    return it;
  endfunction

  task automatic send(vtx_item_t it);
    int g;
    g = burst_mode ? 0 : pick_gap();
    if (g > 0) begin
      vtx_valid = 0;
      repeat (g) @(negedge clk);
    end
    vtx = it;
    vtx_valid = 1;
    do @(posedge clk); while (vtx_stall);
    sb.note_vertex(it);
    @(negedge clk);
  endtask

  task automatic drain();
    vtx_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  localparam logic [31:0] One = 32'h0001_0000;
  localparam logic [31:0] Max = 32'h7FFF_FFFF;
  localparam logic [31:0] Min = 32'h8000_0000;

  initial begin
    vtx_item_t it;
    logic [31:0] su, sv;
    bit same;
    sb = new();
    burst_mode = 0;
    rst = 1;
    vtx_valid = 0;
    vtx = '0;
    repeat (4) @(negedge clk);
    rst = 0;

    send(mk(0, 0, 0, 0, 0, 1));
    send(mk(One, 0, 0, One, 0, 0));
    send(mk(0, One, 0, 0, One, 0));
    send(mk(Max, Max, Max, Max, Max, 0));
    send(mk(Min, Min, Min, Min, Min, 0));
    send(mk(Min, Max, 0, Max, Min, 0));
    // Equal texture coordinates give a zero determinant.
    send(mk(0, 0, 0, 5, 7, 0));
    send(mk(One, 3, 9, 5, 7, 0));
    send(mk(2, One, 4, 5, 7, 0));
    // Coincident positions give a zero tangent.
    send(mk(One, One, One, 0, 0, 0));
    send(mk(One, One, One, One, 0, 0));
    send(mk(One, One, One, 0, One, 0));
    // A mesh start in the middle of a triangle restarts the grouping.
    send(mk(1, 2, 3, 4, 5, 0));
    send(mk(Max, 0, Min, 1, 0, 1));
    send(mk(0, Min, Max, 0, 1, 0));
    send(mk(Min, Min, 0, Max, Max, 0));
    send(mk(1, 0, 0, 0, 0, 1));
    send(mk(0, 1, 0, 1, 0, 0));
    send(mk(0, 0, 1, 0, 1, 0));
    send(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    send(mk(0, 0, 0, 0, 0, 0));
    drain();

    for (int n = 0; n < 1650; n++) begin
      if (n % 150 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if (n == 800) drain();
      if (n % 3 == 0) begin
        same = ($urandom_range(0, 19) == 0);
        su = $urandom;
        sv = $urandom;
      end
      it = rand_vertex($urandom_range(0, 24) == 0, same, su, sv);
      send(it);
    end
    vtx_valid = 0;
    burst_mode = 0;
    drain();
    repeat (400) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/ttb_pkg.sv
hdl/ttb_front.sv
hdl/ttb_back.sv
hdl/triangle_tangent_basis_unit.sv
hdl/ttb_checker.sv
dv/testbench.sv
